>>> hw/rtl/mwia_pkg.sv
// ----------------------------------------------------------------------------
// Multi-width integer ALU package
// Shared codes, types and helper functions for the ALU front, queue and back.
// ----------------------------------------------------------------------------
package mwia_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [4:0] CMD_ADD   = 5'd0;
    localparam logic [4:0] CMD_SUB   = 5'd1;
    localparam logic [4:0] CMD_MUL   = 5'd2;
    localparam logic [4:0] CMD_MULHI = 5'd3;
    localparam logic [4:0] CMD_DIV   = 5'd4;
    localparam logic [4:0] CMD_NEG   = 5'd5;
    localparam logic [4:0] CMD_ABS   = 5'd6;
    localparam logic [4:0] CMD_AND   = 5'd7;
    localparam logic [4:0] CMD_OR    = 5'd8;
    localparam logic [4:0] CMD_XOR   = 5'd9;
    localparam logic [4:0] CMD_NOT   = 5'd10;
    localparam logic [4:0] CMD_SHL   = 5'd11;
    localparam logic [4:0] CMD_SHR   = 5'd12;
    localparam logic [4:0] CMD_SHA   = 5'd13;
    localparam logic [4:0] CMD_BSWAP = 5'd14;
    localparam logic [4:0] CMD_CLZ   = 5'd15;
    localparam logic [4:0] CMD_ZEXT  = 5'd16;
    localparam logic [4:0] CMD_SEXT  = 5'd17;
    localparam logic [4:0] CMD_TRUNC = 5'd18;
    localparam logic [4:0] CMD_CMP   = 5'd19;

    localparam logic [3:0] PRED_EQ  = 4'd0;
    localparam logic [3:0] PRED_NE  = 4'd1;
    localparam logic [3:0] PRED_SLT = 4'd2;
    localparam logic [3:0] PRED_SLE = 4'd3;
    localparam logic [3:0] PRED_SGT = 4'd4;
    localparam logic [3:0] PRED_SGE = 4'd5;
    localparam logic [3:0] PRED_ULT = 4'd6;
    localparam logic [3:0] PRED_ULE = 4'd7;
    localparam logic [3:0] PRED_UGT = 4'd8;
    localparam logic [3:0] PRED_UGE = 4'd9;

    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    typedef enum logic [1:0] {
        UNIT_SIMPLE,
        UNIT_MUL,
        UNIT_DIV
    } t_unit;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [1:0]  wc;
        logic [1:0]  tc;
        logic [63:0] a;
        logic [63:0] b;
        logic [7:0]  amt;
        logic        uns;
        logic [3:0]  pred;
        logic        inv;
        t_unit       unit;
    } t_item;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  rw;
        logic        carry;
        logic        cmp;
        logic        dz;
        logic        inv;
    } t_result;

    function automatic logic [63:0] width_mask(input logic [1:0] wc);
        logic [63:0] m;
        unique case (wc)
            WC_8:    m = 64'h0000_0000_0000_00FF;
            WC_16:   m = 64'h0000_0000_0000_FFFF;
            WC_32:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic sign_bit(input logic [63:0] v, input logic [1:0] wc);
        logic s;
        unique case (wc)
            WC_8:    s = v[7];
            WC_16:   s = v[15];
            WC_32:   s = v[31];
            default: s = v[63];
        endcase
        return s;
    endfunction

    function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [1:0] wc);
        logic [63:0] m;
        m = width_mask(wc);
        return sign_bit(v, wc) ? ((v & m) | ~m) : (v & m);
    endfunction

endpackage

>>> hw/rtl/mwia_front.sv
// ----------------------------------------------------------------------------
// ALU front end
// Masks operands to the operand width, flags invalid combinations and
// picks the execution unit for each transaction.
// ----------------------------------------------------------------------------
module mwia_front (
    input  logic [4:0]     i_command,
    input  logic [1:0]     i_operand_width,
    input  logic [1:0]     i_target_width,
    input  logic [63:0]    i_first_operand,
    input  logic [63:0]    i_second_operand,
    input  logic           i_unsigned_mode,
    input  logic [3:0]     i_predicate,
    output mwia_pkg::t_item o_item
);

    logic [63:0] m;
    logic        inv;

    always_comb begin
        m   = mwia_pkg::width_mask(i_operand_width);
        inv = 1'b0;
        if (i_command > mwia_pkg::CMD_CMP) begin
            inv = 1'b1;
        end
        if (i_command == mwia_pkg::CMD_MULHI && i_operand_width < mwia_pkg::WC_32) begin
            inv = 1'b1;
        end
        if ((i_command == mwia_pkg::CMD_ZEXT || i_command == mwia_pkg::CMD_SEXT)
            && i_target_width <= i_operand_width) begin
            inv = 1'b1;
        end
        if (i_command == mwia_pkg::CMD_TRUNC && i_target_width >= i_operand_width) begin
            inv = 1'b1;
        end
        if (i_command == mwia_pkg::CMD_CMP && i_predicate > mwia_pkg::PRED_UGE) begin
            inv = 1'b1;
        end

        o_item.cmd  = i_command;
        o_item.wc   = i_operand_width;
        o_item.tc   = i_target_width;
        o_item.a    = i_first_operand & m;
        o_item.b    = i_second_operand & m;
        o_item.amt  = i_second_operand[7:0];
        o_item.uns  = i_unsigned_mode;
        o_item.pred = i_predicate;
        o_item.inv  = inv;

        if (inv) begin
            o_item.unit = mwia_pkg::UNIT_SIMPLE;
        end else if (i_command == mwia_pkg::CMD_MUL || i_command == mwia_pkg::CMD_MULHI) begin
            o_item.unit = mwia_pkg::UNIT_MUL;
        end else if (i_command == mwia_pkg::CMD_DIV && (i_second_operand & m) != 64'd0) begin
            o_item.unit = mwia_pkg::UNIT_DIV;
        end else begin
            o_item.unit = mwia_pkg::UNIT_SIMPLE;
        end
    end

endmodule

>>> hw/rtl/mwia_queue.sv
// ----------------------------------------------------------------------------
// ALU transaction queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module mwia_queue #(
    parameter int Depth = mwia_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mwia_pkg::t_item i_data,
    input  logic            i_pop,
    output mwia_pkg::t_item o_data,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    mwia_pkg::t_item r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/mwia_back.sv
// ----------------------------------------------------------------------------
// ALU back end
// Executes queued transactions: simple operations directly, multiply
// through four 32x32 partial products and divide through a restoring loop.
// ----------------------------------------------------------------------------
module mwia_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mwia_pkg::t_item   i_item,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    output mwia_pkg::t_result o_result
);

    mwia_pkg::t_state  r_state, n_state;
    mwia_pkg::t_item   r_item, n_item;
    logic [127:0]      r_acc, n_acc;
    logic [63:0]       r_x, n_x;
    logic [63:0]       r_y, n_y;
    logic [1:0]        r_step, n_step;
    logic [64:0]       r_rem, n_rem;
    logic [63:0]       r_dvd, n_dvd;
    logic [63:0]       r_dsr, n_dsr;
    logic              r_neg, n_neg;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_valid, n_valid;
    mwia_pkg::t_result r_res, n_res;

    mwia_pkg::t_result simple_res;
    mwia_pkg::t_result fin_res;
    logic [31:0]       mul_x;
    logic [31:0]       mul_y;
    logic [63:0]       pp;
    logic [127:0]      pp_sh;
    logic [64:0]       rem_sh;

    assign o_valid  = r_valid;
    assign o_result = r_res;

    always_comb begin
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] b;
        logic [7:0]  w;
        logic [64:0] sum;
        logic [63:0] sa;
        logic [63:0] sb;
        logic [63:0] t;
        logic [6:0]  n;
        logic        found;

        m     = mwia_pkg::width_mask(i_item.wc);
        a     = i_item.a;
        b     = i_item.b;
        w     = 8'd8 << i_item.wc;
        sum   = {1'b0, a} + {1'b0, b};
        sa    = mwia_pkg::sign_ext(a, i_item.wc) ^ 64'h8000_0000_0000_0000;
        sb    = mwia_pkg::sign_ext(b, i_item.wc) ^ 64'h8000_0000_0000_0000;
        t     = a << (7'd64 - 7'(w));
        n     = 7'd0;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && t[i]) begin
                found = 1'b1;
                n     = 7'(63 - i);
            end
        end

        simple_res       = '0;
        simple_res.rw    = i_item.wc;
        unique case (i_item.cmd)
            mwia_pkg::CMD_ADD: begin
                simple_res.value = sum[63:0] & m;
                simple_res.carry = (sum > {1'b0, m});
            end
            mwia_pkg::CMD_SUB: begin
                simple_res.value = (a - b) & m;
                simple_res.carry = (a >= b);
            end
            mwia_pkg::CMD_DIV: simple_res.dz = 1'b1;
            mwia_pkg::CMD_NEG: simple_res.value = (64'd0 - a) & m;
            mwia_pkg::CMD_ABS: begin
                simple_res.value = mwia_pkg::sign_bit(a, i_item.wc) ? ((64'd0 - a) & m) : a;
            end
            mwia_pkg::CMD_AND: simple_res.value = a & b;
            mwia_pkg::CMD_OR:  simple_res.value = a | b;
            mwia_pkg::CMD_XOR: simple_res.value = a ^ b;
            mwia_pkg::CMD_NOT: simple_res.value = ~a & m;
            mwia_pkg::CMD_SHL: begin
                simple_res.value = (i_item.amt >= w) ? 64'd0 : ((a << i_item.amt) & m);
            end
            mwia_pkg::CMD_SHR: begin
                simple_res.value = (i_item.amt >= w) ? 64'd0 : (a >> i_item.amt);
            end
            mwia_pkg::CMD_SHA: begin
                if (i_item.amt >= w) begin
                    simple_res.value = mwia_pkg::sign_bit(a, i_item.wc) ? m : 64'd0;
                end else begin
                    simple_res.value = 64'($signed(mwia_pkg::sign_ext(a, i_item.wc))
                                           >>> i_item.amt) & m;
                end
            end
            mwia_pkg::CMD_BSWAP: begin
                unique case (i_item.wc)
                    mwia_pkg::WC_8:  simple_res.value = a;
                    mwia_pkg::WC_16: simple_res.value = {48'd0, a[7:0], a[15:8]};
                    mwia_pkg::WC_32: begin
                        simple_res.value = {32'd0, a[7:0], a[15:8], a[23:16], a[31:24]};
                    end
                    default: begin
                        simple_res.value = {a[7:0], a[15:8], a[23:16], a[31:24],
                                            a[39:32], a[47:40], a[55:48], a[63:56]};
                    end
                endcase
            end
            mwia_pkg::CMD_CLZ: begin
                simple_res.value = (a == 64'd0) ? {56'd0, w} : {57'd0, n};
                simple_res.rw    = mwia_pkg::WC_8;
            end
            mwia_pkg::CMD_ZEXT: begin
                simple_res.value = a;
                simple_res.rw    = i_item.tc;
            end
            mwia_pkg::CMD_SEXT: begin
                simple_res.value = mwia_pkg::sign_ext(a, i_item.wc)
                                   & mwia_pkg::width_mask(i_item.tc);
                simple_res.rw    = i_item.tc;
            end
            mwia_pkg::CMD_TRUNC: begin
                simple_res.value = a & mwia_pkg::width_mask(i_item.tc);
                simple_res.rw    = i_item.tc;
            end
            mwia_pkg::CMD_CMP: begin
                unique case (i_item.pred)
                    mwia_pkg::PRED_EQ:  simple_res.cmp = (a == b);
                    mwia_pkg::PRED_NE:  simple_res.cmp = (a != b);
                    mwia_pkg::PRED_SLT: simple_res.cmp = (sa < sb);
                    mwia_pkg::PRED_SLE: simple_res.cmp = (sa <= sb);
                    mwia_pkg::PRED_SGT: simple_res.cmp = (sa > sb);
                    mwia_pkg::PRED_SGE: simple_res.cmp = (sa >= sb);
                    mwia_pkg::PRED_ULT: simple_res.cmp = (a < b);
                    mwia_pkg::PRED_ULE: simple_res.cmp = (a <= b);
                    mwia_pkg::PRED_UGT: simple_res.cmp = (a > b);
                    default:            simple_res.cmp = (a >= b);
                endcase
                simple_res.value = {63'd0, simple_res.cmp};
                simple_res.rw    = mwia_pkg::WC_8;
            end
            default: simple_res.value = 64'd0;
        endcase

        if (i_item.inv) begin
            simple_res     = '0;
            simple_res.rw  = i_item.wc;
            simple_res.inv = 1'b1;
        end
    end

    always_comb begin
        logic [63:0] m;
        logic [63:0] hi;
        logic [63:0] q;

        m  = mwia_pkg::width_mask(r_item.wc);
        hi = r_acc[127:64];
        if (!r_item.uns && mwia_pkg::sign_bit(r_item.a, r_item.wc)) begin
            hi = hi - r_item.b;
        end
        if (!r_item.uns && mwia_pkg::sign_bit(r_item.b, r_item.wc)) begin
            hi = hi - r_item.a;
        end
        q = r_neg ? (64'd0 - r_dvd) : r_dvd;

        fin_res    = '0;
        fin_res.rw = r_item.wc;
        if (r_item.cmd == mwia_pkg::CMD_DIV) begin
            fin_res.value = q & m;
        end else if (r_item.cmd == mwia_pkg::CMD_MUL) begin
            fin_res.value = r_acc[63:0] & m;
        end else if (r_item.wc == mwia_pkg::WC_32) begin
            fin_res.value = {32'd0, r_acc[63:32]};
        end else begin
            fin_res.value = hi;
        end
    end

    always_comb begin
        mul_x  = r_step[0] ? r_x[63:32] : r_x[31:0];
        mul_y  = r_step[1] ? r_y[63:32] : r_y[31:0];
        pp     = mul_x * mul_y;
        unique case ({1'b0, r_step[0]} + {1'b0, r_step[1]})
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        rem_sh = {r_rem[63:0], r_dvd[63]};
    end

    always_comb begin
        logic        na;
        logic        nb;
        logic [63:0] sxa;
        logic [63:0] sxb;

        na  = mwia_pkg::sign_bit(i_item.a, i_item.wc) && !i_item.uns;
        nb  = mwia_pkg::sign_bit(i_item.b, i_item.wc) && !i_item.uns;
        sxa = mwia_pkg::sign_ext(i_item.a, i_item.wc);
        sxb = mwia_pkg::sign_ext(i_item.b, i_item.wc);

        n_state = r_state;
        n_item  = r_item;
        n_acc   = r_acc;
        n_x     = r_x;
        n_y     = r_y;
        n_step  = r_step;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_dsr   = r_dsr;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_res   = r_res;
        o_pop   = 1'b0;

        unique case (r_state)
            mwia_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    unique case (i_item.unit)
                        mwia_pkg::UNIT_MUL: begin
                            n_state = mwia_pkg::ST_MUL;
                            n_acc   = '0;
                            n_step  = '0;
                            if (i_item.cmd == mwia_pkg::CMD_MULHI && !i_item.uns
                                && i_item.wc == mwia_pkg::WC_32) begin
                                n_x = sxa;
                                n_y = sxb;
                            end else begin
                                n_x = i_item.a;
                                n_y = i_item.b;
                            end
                        end
                        mwia_pkg::UNIT_DIV: begin
                            n_state = mwia_pkg::ST_DIV;
                            n_rem   = '0;
                            n_cnt   = '0;
                            n_dvd   = na ? (64'd0 - sxa) : i_item.a;
                            n_dsr   = nb ? (64'd0 - sxb) : i_item.b;
                            n_neg   = na ^ nb;
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_res   = simple_res;
                        end
                    endcase
                end
            end
            mwia_pkg::ST_MUL: begin
                n_acc  = r_acc + pp_sh;
                n_step = r_step + 1'b1;
                if (r_step == 2'd3) begin
                    n_state = mwia_pkg::ST_FIN;
                end
            end
            mwia_pkg::ST_DIV: begin
                if (rem_sh >= {1'b0, r_dsr}) begin
                    n_rem = rem_sh - {1'b0, r_dsr};
                    n_dvd = {r_dvd[62:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_dvd = {r_dvd[62:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    n_state = mwia_pkg::ST_FIN;
                end
            end
            default: begin
                n_valid = 1'b1;
                n_res   = fin_res;
                n_state = mwia_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwia_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_acc  <= n_acc;
        r_x    <= n_x;
        r_y    <= n_y;
        r_step <= n_step;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_dsr  <= n_dsr;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

endmodule

>>> hw/rtl/multi_width_integer_alu.sv
// ----------------------------------------------------------------------------
// Multi-width integer ALU
// An accepted transaction is queued, then popped by the back end, which
// registers its result; multiply and divide pass through ST_MUL or ST_DIV and
// ST_FIN (4 partial products, one 32x32 multiplier, 64 restoring divide steps).
// Throughput: one simple operation per clock; the back end is held by
// multiply and divide, and busy rises when the two-entry queue is full.
// Reset empties the queue and idles the back end; the receiver cannot stall.
// ----------------------------------------------------------------------------
module multi_width_integer_alu #(
    parameter int QueueDepth = mwia_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  i_command,
    input  logic [1:0]  i_operand_width,
    input  logic [1:0]  i_target_width,
    input  logic [63:0] i_first_operand,
    input  logic [63:0] i_second_operand,
    input  logic        i_unsigned_mode,
    input  logic [3:0]  i_predicate,
    output logic        o_result_valid,
    output logic [63:0] o_result_value,
    output logic [1:0]  o_result_width,
    output logic        o_carry_out,
    output logic        o_compare_true,
    output logic        o_divide_by_zero,
    output logic        o_invalid_op
);

    mwia_pkg::t_item   front_item;
    mwia_pkg::t_item   head_item;
    mwia_pkg::t_result res;
    logic              full;
    logic              empty;
    logic              pop;

    assign busy = full;

    mwia_front u_front (
        .i_command        (i_command),
        .i_operand_width  (i_operand_width),
        .i_target_width   (i_target_width),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_unsigned_mode  (i_unsigned_mode),
        .i_predicate      (i_predicate),
        .o_item           (front_item)
    );

    mwia_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !full),
        .i_data  (front_item),
        .i_pop   (pop),
        .o_data  (head_item),
        .o_full  (full),
        .o_empty (empty)
    );

    mwia_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (head_item),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_result_valid),
        .o_result (res)
    );

    assign o_result_value   = res.value;
    assign o_result_width   = res.rw;
    assign o_carry_out      = res.carry;
    assign o_compare_true   = res.cmp;
    assign o_divide_by_zero = res.dz;
    assign o_invalid_op     = res.inv;

endmodule
